// ===== hw/rtl/rrwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrwlt_pkg: shared types and codes for the record lock table
// Request and status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package rrwlt_pkg;

   localparam int REQ_TYPE_W  = 2;
   localparam int RECORD_ID_W = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 8;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] OP_ACQ_RD = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_REL_RD = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_ACQ_WR = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_REL_WR = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_UPDATE = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/rrwlt_req_if.sv =====
// ----------------------------------------------------------------------------
// rrwlt_req_if: lock request channel
// Valid/ready channel carrying one lock request word.
// ----------------------------------------------------------------------------
interface rrwlt_req_if;
   import rrwlt_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [REQ_TYPE_W-1:0]         req_type;
   logic signed [RECORD_ID_W-1:0] record_id;

   modport source (output valid, output req_type, output record_id, input ready);
   modport sink   (input valid, input req_type, input record_id, output ready);

endinterface

// ===== hw/rtl/rrwlt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrwlt_rsp_if: lock response channel
// Valid/ready channel carrying one lock response word.
// ----------------------------------------------------------------------------
interface rrwlt_rsp_if;
   import rrwlt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  reader_count;
   logic                writer_held;

   modport source (output valid, output status, output reader_count,
                   output writer_held, input ready);
   modport sink   (input valid, input status, input reader_count,
                   input writer_held, output ready);

endinterface

// ===== hw/rtl/record_reader_writer_lock_table.sv =====
// ----------------------------------------------------------------------------
// record_reader_writer_lock_table: reader/writer lock table for records
// Looks a record id up in a slot table, claims a slot for a new id, and
// grants or refuses read and write locks at once (no waiting).
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake    word
//   req_chan  in   valid/ready  req_type[1:0], record_id[31:0] (signed)
//   rsp_chan  out  valid/ready  status[1:0], reader_count[7:0], writer_held
//
// A request's time from accept to response valid grows with fill, the
//   number of claimed slots (at most LOCK_SLOTS); the linear key scan
//   through the slot memory, one slot a cycle, sets it. A claim is the
//   slowest case, a hit or a full table is faster.
// One request at a time: req_chan.ready is high only while idle.
// Reset clears the fill count and the sequencer; slot contents need none,
//   since slots are claimed in order and only slots below the fill count
//   are ever read.
// A stalled response holds its word until rsp_chan.ready.
// ----------------------------------------------------------------------------
module record_reader_writer_lock_table #(
   parameter int LOCK_SLOTS  = 16,
   parameter int READER_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   rrwlt_req_if.sink   req_chan,
   rrwlt_rsp_if.source rsp_chan
);
   import rrwlt_pkg::*;

   localparam int IW    = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
   localparam int CW    = $clog2(LOCK_SLOTS + 1);
   localparam int ENT_W = RECORD_ID_W + READER_BITS + 1;

   localparam logic [CW-1:0]          SLOTS_CNT  = CW'(LOCK_SLOTS);
   localparam logic [READER_BITS-1:0] READER_MAX = '1;

   // sequencer and request registers
   state_type                state_ff, state_in;
   logic [REQ_TYPE_W-1:0]    op_ff, op_in;
   logic [RECORD_ID_W-1:0]   key_ff, key_in;

   // scan control
   logic [CW-1:0]            scan_ff, scan_in;
   logic                     pend_ff, pend_in;
   logic [IW-1:0]            pend_idx_ff, pend_idx_in;
   logic [CW-1:0]            fill_ff, fill_in;

   // selected slot and its current lock state
   logic [IW-1:0]            slot_ff, slot_in;
   logic [READER_BITS-1:0]   cur_rd_ff, cur_rd_in;
   logic                     cur_wr_ff, cur_wr_in;

   // response word
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     writer_ff, writer_in;

   // slot memory: {key, readers, writer}
   logic [ENT_W-1:0]         slot_mem [LOCK_SLOTS];
   logic [ENT_W-1:0]         rd_ff;
   logic                     rd_en;
   logic                     wr_en;
   logic [ENT_W-1:0]         wr_data;

   logic [RECORD_ID_W-1:0]   rd_key;
   logic [READER_BITS-1:0]   rd_readers;
   logic                     rd_writer;
   logic                     hit;
   logic                     miss;

   logic [READER_BITS-1:0]   new_rd;
   logic                     new_wr;
   logic [STATUS_W-1:0]      new_status;

   assign rd_key     = rd_ff[ENT_W-1 -: RECORD_ID_W];
   assign rd_readers = rd_ff[READER_BITS:1];
   assign rd_writer  = rd_ff[0];

   // read the next claimed slot while scanning
   assign rd_en = (state_ff == S_SCAN) && (scan_ff < fill_ff);
   assign hit   = pend_ff && (rd_key == key_ff);
   // nothing in flight and nothing left to read: the id is absent
   assign miss  = !pend_ff && !rd_en;

   // lock rules applied to the selected slot
   always_comb begin
      new_rd     = cur_rd_ff;
      new_wr     = cur_wr_ff;
      new_status = ST_OK;
      case (op_ff)
         OP_ACQ_RD: begin
            if (cur_wr_ff || cur_rd_ff == READER_MAX) begin
               new_status = ST_BUSY;
            end else begin
               new_rd = cur_rd_ff + 1'b1;
            end
         end
         OP_REL_RD: begin
            if (cur_rd_ff != '0) begin
               new_rd = cur_rd_ff - 1'b1;
            end
         end
         OP_ACQ_WR: begin
            if (cur_rd_ff != '0 || cur_wr_ff) begin
               new_status = ST_BUSY;
            end else begin
               new_wr = 1'b1;
            end
         end
         OP_REL_WR: begin
            new_wr = 1'b0;
         end
         default: begin
            new_status = ST_OK;
         end
      endcase
   end

   assign wr_en   = (state_ff == S_UPDATE);
   assign wr_data = {key_ff, new_rd, new_wr};

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = scan_ff[IW-1:0];
      fill_in     = fill_ff;
      slot_in     = slot_ff;
      cur_rd_in   = cur_rd_ff;
      cur_wr_in   = cur_wr_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      writer_in   = writer_ff;

      case (state_ff)
         S_IDLE: begin
            // take a word and start the scan at slot zero
            if (req_chan.valid) begin
               op_in    = req_chan.req_type;
               key_in   = req_chan.record_id;
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               scan_in = CW'(scan_ff + 1'b1);
               pend_in = 1'b1;
            end
            if (hit) begin
               slot_in   = pend_idx_ff;
               cur_rd_in = rd_readers;
               cur_wr_in = rd_writer;
               state_in  = S_UPDATE;
            end else if (miss) begin
               if (fill_ff < SLOTS_CNT) begin
                  // claim the lowest free slot: empty lock
                  slot_in   = fill_ff[IW-1:0];
                  cur_rd_in = '0;
                  cur_wr_in = 1'b0;
                  fill_in   = CW'(fill_ff + 1'b1);
                  state_in  = S_UPDATE;
               end else begin
                  status_in = ST_FULL;
                  count_in  = '0;
                  writer_in = 1'b0;
                  state_in  = S_RESP;
               end
            end
         end
         S_UPDATE: begin
            status_in = new_status;
            count_in  = COUNT_W'(new_rd);
            writer_in = new_wr;
            state_in  = S_RESP;
         end
         S_RESP: begin
            // hold the word until taken
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      cur_rd_ff   <= cur_rd_in;
      cur_wr_ff   <= cur_wr_in;
      status_ff   <= status_in;
      count_ff    <= count_in;
      writer_ff   <= writer_in;
   end

   // slot memory: one read port for the scan, one write port for the update
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= slot_mem[scan_ff[IW-1:0]];
      end
      if (wr_en) begin
         slot_mem[slot_ff] <= wr_data;
      end
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = (state_ff == S_RESP);
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.reader_count = count_ff;
   assign rsp_chan.writer_held  = writer_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= SLOTS_CNT)
      else $error("fill count beyond slot count");

   a_full_only_when_filled: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_FULL |-> fill_ff == SLOTS_CNT)
      else $error("table full answered with free slots");

   a_write_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == ST_OK && op_ff == OP_ACQ_WR
      |-> rsp_chan.writer_held && rsp_chan.reader_count == '0)
      else $error("write granted without exclusive hold");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      fill_ff != $past(fill_ff) |-> $past(state_ff) == S_SCAN
                                    && fill_ff == CW'($past(fill_ff) + 1'b1))
      else $error("fill count moved outside a claim");

endmodule

// ===== tb/lock_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lock_scoreboard_pkg: lock table predictor and response checker
// Keeps a shadow of the slot table, works out the response word for every
// accepted request and compares the responses in order against it.
// ----------------------------------------------------------------------------
package lock_scoreboard_pkg;
   import rrwlt_pkg::*;

   localparam int              TABLE_SLOTS = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  readers;
      logic                writer;
   } lock_word_type;

   class lock_scoreboard;
      bit                     slot_in_use [TABLE_SLOTS];
      logic [RECORD_ID_W-1:0] slot_id     [TABLE_SLOTS];
      logic [COUNT_W-1:0]     slot_count  [TABLE_SLOTS];
      bit                     slot_writer [TABLE_SLOTS];
      lock_word_type          expected_q[$];
      int unsigned            errors;

      function new();
         foreach (slot_in_use[i]) slot_in_use[i] = 1'b0;
         errors = 0;
      endfunction

      // look the id up; claim the lowest free slot on a miss, -1 when full
      function int claim_slot(logic [RECORD_ID_W-1:0] id);
         foreach (slot_in_use[i])
            if (slot_in_use[i] && slot_id[i] == id) return i;
         foreach (slot_in_use[i]) begin
            if (!slot_in_use[i]) begin
               slot_in_use[i] = 1'b1;
               slot_id[i]     = id;
               slot_count[i]  = '0;
               slot_writer[i] = 1'b0;
               return i;
            end
         end
         return -1;
      endfunction

      function void note_request(logic [REQ_TYPE_W-1:0] op, logic [RECORD_ID_W-1:0] id);
         int            slot;
         lock_word_type w;
         slot     = claim_slot(id);
         w.status = ST_OK;
         if (slot < 0) begin
            w.status  = ST_FULL;
            w.readers = '0;
            w.writer  = 1'b0;
         end else begin
            case (op)
               OP_ACQ_RD: begin
                  if (slot_writer[slot] || slot_count[slot] == COUNT_MAX) w.status = ST_BUSY;
                  else slot_count[slot] = slot_count[slot] + 1'b1;
               end
               OP_REL_RD: begin
                  if (slot_count[slot] != 0) slot_count[slot] = slot_count[slot] - 1'b1;
               end
               OP_ACQ_WR: begin
                  if (slot_count[slot] != 0 || slot_writer[slot]) w.status = ST_BUSY;
                  else slot_writer[slot] = 1'b1;
               end
               default: begin
                  slot_writer[slot] = 1'b0;
               end
            endcase
            w.readers = slot_count[slot];
            w.writer  = slot_writer[slot];
         end
         expected_q.push_back(w);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] readers,
                                   logic writer);
         lock_word_type w;
         if (expected_q.size() == 0) begin
            $display("%0t: response word with none pending: status %0d count %0d writer %0d",
                     $time, status, readers, writer);
            errors++;
            return;
         end
         w = expected_q.pop_front();
         if (status !== w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, status);
            errors++;
         end
         if (readers !== w.readers) begin
            $display("%0t: reader_count expected %0d actual %0d", $time, w.readers, readers);
            errors++;
         end
         if (writer !== w.writer) begin
            $display("%0t: writer_held expected %0d actual %0d", $time, w.writer, writer);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the record lock table
// Drives lock requests through the request channel in random bursts, drains
// responses with a stalling sink and checks every response word against a
// shadow model of the slot table kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb;
   import rrwlt_pkg::*;
   import lock_scoreboard_pkg::*;

   localparam int RANDOM_WORDS  = 1330;  // stop point for the random phase
   localparam int HOLD_CYCLES   = 300;   // long sink hold-off, fills the block
   localparam int SETTLE_CYCLES = 40;    // idle time after the final drain
   localparam int SAT_RUN       = 258;   // enough read grabs to pin the count

   typedef enum int {
      SINK_OPEN,
      SINK_LOOSE,
      SINK_PATTERN,
      SINK_TIGHT
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset;

   rrwlt_req_if req_chan ();
   rrwlt_rsp_if rsp_chan ();

   lock_scoreboard         sb;
   logic [RECORD_ID_W-1:0] known_ids[$];   // ids that own a slot, in claim order
   int unsigned            burst_left;
   int unsigned            sent_words;
   bit                     hold_off_req;

   record_reader_writer_lock_table u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // Offer one request word and hold it until the block takes it. Keep valid
   // high into the next word inside a burst; between bursts drop it and idle, unless the random gap is zero.
   task automatic send_word(input logic [REQ_TYPE_W-1:0] op, input logic [RECORD_ID_W-1:0] id);
      int unsigned gap;
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= op;
      req_chan.record_id <= id;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, id);
      sent_words++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 30);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold the sender until every pending response is back.
   task automatic settle_pending();
      if (req_chan.valid) req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [REQ_TYPE_W-1:0]  op;
      logic [RECORD_ID_W-1:0] id;
      int unsigned            pick;
      int unsigned            n;
      bit                     sat_done;

      sb = new();
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= OP_ACQ_RD;
      req_chan.record_id <= '0;
      burst_left   = 1;
      sent_words   = 0;
      hold_off_req = 1'b0;
      sat_done     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // -- directed: lock rules on one record ---------------------------------
      send_word(OP_ACQ_RD, 32'h0000_0000);   // unknown id claims slot, read granted
      send_word(OP_ACQ_WR, 32'h0000_0000);   // writer refused while a reader holds
      send_word(OP_REL_RD, 32'h0000_0000);
      send_word(OP_REL_RD, 32'h0000_0000);   // release-read with no readers
      send_word(OP_ACQ_WR, 32'h0000_0000);
      send_word(OP_ACQ_RD, 32'h0000_0000);   // reader refused while writer holds
      send_word(OP_REL_WR, 32'h0000_0000);
      send_word(OP_REL_WR, 32'h0000_0000);   // release-write with no writer

      // -- directed: releases and acquires on fresh ids, id extremes -----------
      send_word(OP_REL_RD, 32'h7FFF_FFFF);
      send_word(OP_REL_WR, 32'h8000_0000);
      send_word(OP_ACQ_WR, 32'hFFFF_FFFF);
      send_word(OP_ACQ_RD, 32'h8000_0000);
      known_ids = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

      // -- directed: claim the remaining slots, then overflow the table ---------
      for (int i = 1; i <= TABLE_SLOTS - 4; i++) begin
         op = i[1:0];
         id = i;
         send_word(op, id);
         known_ids.push_back(id);
      end
      send_word(OP_ACQ_RD, 32'h5A5A_C3C3);   // no slot left: table full

      // pause the sender until the directed words are all answered
      settle_pending();

      // ask the sink for its long hold-off; the sender keeps offering meanwhile
      hold_off_req = 1'b1;

      // -- random: mostly well-formed lock sessions on owned records -----------
      while (sent_words < 25 + RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         id   = known_ids[$urandom_range(0, known_ids.size() - 1)];
         if (!sat_done && sent_words > 400) begin
            // pin one record's reader count at its ceiling, then bleed it to zero
            sat_done = 1'b1;
            send_word(OP_REL_WR, id);
            repeat (SAT_RUN) send_word(OP_ACQ_RD, id);
            send_word(OP_ACQ_WR, id);
            repeat (SAT_RUN) send_word(OP_REL_RD, id);
         end else if (pick < 35) begin
            // overlapping readers, with a writer trying to cut in
            n = $urandom_range(1, 4);
            repeat (n) send_word(OP_ACQ_RD, id);
            if ($urandom_range(0, 1) != 0) send_word(OP_ACQ_WR, id);
            repeat (n) send_word(OP_REL_RD, id);
         end else if (pick < 60) begin
            // exclusive writer, with readers and a second writer refused
            send_word(OP_ACQ_WR, id);
            if ($urandom_range(0, 1) != 0) send_word(OP_ACQ_RD, id);
            if ($urandom_range(0, 1) != 0) send_word(OP_ACQ_WR, id);
            send_word(OP_REL_WR, id);
         end else if (pick < 85) begin
            // noise on an owned record
            op = REQ_TYPE_W'($urandom_range(0, 3));
            send_word(op, id);
         end else begin
            // random id: almost always absent, so the table answers full
            op = REQ_TYPE_W'($urandom_range(0, 3));
            id = $urandom();
            send_word(op, id);
         end
      end

      // drain, then give the block time to emit anything it should not
      settle_pending();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("[record_reader_writer_lock_table] OK");
      end else begin
         $display("[record_reader_writer_lock_table] ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: check each word taken, then pick the next ready value
   // ------------------------------------------------------------------------
   initial begin : response_sink
      sink_mode_type mode;
      int unsigned   phase_left;
      int unsigned   hold_left;
      int unsigned   beat;
      bit            hold_taken;
      logic [7:0]    pattern;

      rsp_chan.ready <= 1'b0;
      mode       = SINK_OPEN;
      phase_left = 0;
      hold_left  = 0;
      beat       = 0;
      hold_taken = 1'b0;
      pattern    = '1;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.status, rsp_chan.reader_count, rsp_chan.writer_held);

         // take the long hold-off once, counted here in sink cycles
         if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end

         // advance to a new stall pattern every so often
         if (phase_left == 0) begin
            mode       = sink_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(20, 200);
            pattern    = 8'($urandom());
         end
         phase_left--;
         beat++;

         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               SINK_OPEN:    rsp_chan.ready <= 1'b1;
               SINK_LOOSE:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               SINK_PATTERN: rsp_chan.ready <= pattern[beat % 8];
               default:      rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // hang guard, several times the slowest legal run
   // ------------------------------------------------------------------------
   initial begin : watchdog
      #40_000_000;
      $display("[record_reader_writer_lock_table] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rrwlt_pkg.sv
hw/rtl/rrwlt_req_if.sv
hw/rtl/rrwlt_rsp_if.sv
hw/rtl/record_reader_writer_lock_table.sv
tb/lock_scoreboard_pkg.sv
tb/tb.sv
